// ===== src/tfl_pkg.sv =====
// Shared types, constants and lookup functions for the thermistor filter and linearizer.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package tfl_pkg;

  localparam int ADC_W   = 12;
  localparam int TEMP_W  = 9;
  localparam int MODE_W  = 2;
  localparam int ROW_W   = 5;   // widest row index the lookup functions take
  localparam int DLT_W   = 12;  // level minus lower breakpoint
  localparam int PROD_W  = 21;  // DLT_W + TEMP_W
  localparam int QUOT_W  = 9;   // interpolation step always below the row spacing
  localparam int DIV_CNT_W = 4;

  localparam int DEFAULT_ROWS = 14;
  localparam int BED_SENSOR   = 1;

  localparam logic [ADC_W-1:0] BED_MIN_GOOD = 12'd300;
  localparam logic [ADC_W-1:0] ADC_MAX      = 12'd4095;

  // operation codes on the mode field
  localparam logic [MODE_W-1:0] MODE_CONVERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  localparam logic [ADC_W-1:0] INIT_EXT [DEFAULT_ROWS] = '{
    12'd860, 12'd1849, 12'd2208, 12'd2711, 12'd2960, 12'd3332, 12'd3568,
    12'd3711, 12'd3870, 12'd3960, 12'd4032, 12'd4062, 12'd4070, 12'd4080};

  localparam logic [ADC_W-1:0] INIT_BED [DEFAULT_ROWS] = '{
    12'd60, 12'd95, 12'd119, 12'd215, 12'd293, 12'd447, 12'd641,
    12'd865, 12'd1408, 12'd1906, 12'd2732, 12'd3352, 12'd3755, 12'd4085};

  localparam logic [TEMP_W-1:0] INIT_TEMP [DEFAULT_ROWS] = '{
    9'd300, 9'd248, 9'd226, 9'd198, 9'd183, 9'd163, 9'd145,
    9'd131, 9'd105, 9'd86, 9'd64, 9'd42, 9'd22, 9'd0};

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DLT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  // rows past the default table repeat its last row
  function automatic logic [3:0] default_row(input logic [ROW_W-1:0] row);
    logic [3:0] d;
    d = (row < ROW_W'(DEFAULT_ROWS)) ? row[3:0] : 4'(DEFAULT_ROWS - 1);
    return d;
  endfunction

  function automatic logic [TEMP_W-1:0] row_temp(input logic [ROW_W-1:0] row);
    return INIT_TEMP[default_row(row)];
  endfunction

  function automatic logic [ADC_W-1:0] default_entry(input logic [ROW_W-1:0] row,
                                                     input logic bed);
    logic [3:0] d;
    d = default_row(row);
    return bed ? INIT_BED[d] : INIT_EXT[d];
  endfunction

endpackage

// ===== src/tfl_bp_table.sv =====
// Breakpoint table memory: one ADC entry per row and sensor, registered read.
// Depends on tfl_pkg for the reset contents; valid bits stand in for the reset load.
`timescale 1ns / 1ps

module tfl_bp_table #(
  parameter int TABLE_ROWS   = 14,
  parameter int SENSOR_COUNT = 2,
  localparam int RW = $clog2(TABLE_ROWS),
  localparam int SW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [RW-1:0]            row_i,
  input  logic [SW-1:0]            sens_i,
  input  logic                     wr_en_i,
  input  logic [tfl_pkg::ADC_W-1:0] wr_data_i,
  output logic [tfl_pkg::ADC_W-1:0] rd_data_o
);
  import tfl_pkg::*;

  logic [ADC_W-1:0] mem [TABLE_ROWS][SENSOR_COUNT];
  logic             vld_q [TABLE_ROWS][SENSOR_COUNT];
  logic [ADC_W-1:0] mem_rd_q;
  logic [ADC_W-1:0] dflt_q;
  logic             vld_rd_q;
  logic             is_bed;

  assign is_bed = (sens_i == SW'(BED_SENSOR));

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[row_i][sens_i] <= wr_data_i;
    end
    mem_rd_q <= mem[row_i][sens_i];
    dflt_q   <= default_entry(ROW_W'(row_i), is_bed);
  end

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < TABLE_ROWS; r++) begin
        for (int s = 0; s < SENSOR_COUNT; s++) begin
          vld_q[r][s] <= 1'b0;
        end
      end
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[row_i][sens_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[row_i][sens_i];
    end
  end

  // an entry never written reads as its reset value
  assign rd_data_o = vld_rd_q ? mem_rd_q : dflt_q;

endmodule

// ===== src/tfl_div.sv =====
// Bit-serial restoring divider, one quotient bit a cycle.
// Depends on tfl_pkg for the request and response structs.
`timescale 1ns / 1ps

module tfl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfl_pkg::div_req_t req_i,
  output tfl_pkg::div_rsp_t rsp_o
);
  import tfl_pkg::*;

  logic [PROD_W-1:0]    rem_q;
  logic [PROD_W-1:0]    dsh_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 ge;

  assign ge = (rem_q >= dsh_q);

  // load on start, then one compare and subtract per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= req_i.dividend;
        dsh_q  <= PROD_W'(req_i.divisor) << (QUOT_W - 1);
        quot_q <= '0;
        cnt_q  <= DIV_CNT_W'(QUOT_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quot_q <= {quot_q[QUOT_W-2:0], ge};
        dsh_q  <= dsh_q >> 1;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

// ===== src/thermistor_filter_linearizer.sv =====
// Top level of the thermistor filter and linearizer: sequencer, IIR filter and output register.
// Depends on tfl_pkg, tfl_bp_table and tfl_div.
//
// Usage: one input beat (mode, sensor, sample, temp_key, adc_entry) gives exactly one
// output beat (celsius, found, entry_value). Both channels use valid/stall; a beat moves
// when valid is high and stall is low. in_stall_o is high while an item is in work.
// Convert: the bed sample is cleaned, the sensor's IIR level updated, then the breakpoint
// column is searched one row per cycle through the single table read port and the
// interpolation runs through a serial divider. A level below the first breakpoint, or at or
// above the last, takes that end row's temperature with no search or division.
// Write and read by key scan the fixed row temperatures one per cycle, and a bad mode or
// sensor returns an all-zero beat.
// Items are taken one at a time; the next one can be accepted in the cycle after the result
// enters the output register, so that register lets it be accepted while the previous
// result is still stalled, and a finished result waits in its holding register until
// the output register is free.
// Reset: filter levels and the last good bed sample go to 4095, every table entry
// reads its power-up breakpoint until written, and no output beat is pending.
`timescale 1ns / 1ps

module thermistor_filter_linearizer #(
  parameter int TABLE_ROWS   = 14,
  parameter int SENSOR_COUNT = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tfl_pkg::MODE_W-1:0] mode_i,
  input  logic                       sensor_i,
  input  logic [tfl_pkg::ADC_W-1:0]  sample_i,
  input  logic [tfl_pkg::TEMP_W-1:0] temp_key_i,
  input  logic [tfl_pkg::ADC_W-1:0]  adc_entry_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tfl_pkg::TEMP_W-1:0] celsius_o,
  output logic                       found_o,
  output logic [tfl_pkg::ADC_W-1:0]  entry_value_o
);
  import tfl_pkg::*;

  localparam int RW = $clog2(TABLE_ROWS);
  localparam int SW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(TABLE_ROWS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILT, S_CHK0, S_CHKL, S_SCAN, S_PREP, S_MUL, S_DIVW, S_KEY, S_RDE, S_DONE
  } state_e;

  state_e state_q;

  logic [MODE_W-1:0] mode_q;
  logic [SW-1:0]     sens_q;
  logic [ADC_W-1:0]  sample_q;
  logic [TEMP_W-1:0] key_q;
  logic [ADC_W-1:0]  entry_q;

  logic [ADC_W-1:0]  filt_q [SENSOR_COUNT];
  logic [ADC_W-1:0]  last_good_q;
  logic [ADC_W-1:0]  lvl_q;
  logic [RW-1:0]     row_q;
  logic [ADC_W-1:0]  a0_q;
  logic [ADC_W-1:0]  a1_q;
  logic [TEMP_W-1:0] t0_q;
  logic [DLT_W-1:0]  dlt_q;
  logic [DLT_W-1:0]  den_q;
  logic [TEMP_W-1:0] dmag_q;
  logic              dneg_q;

  logic [TEMP_W-1:0] res_cel_q;
  logic              res_found_q;
  logic [ADC_W-1:0]  res_entry_q;
  logic              out_valid_q;
  logic [TEMP_W-1:0] celsius_q;
  logic              found_q;
  logic [ADC_W-1:0]  entry_value_q;

  logic              in_take;
  logic              sens_ok;
  logic              is_bed;
  logic              bed_low;
  logic [ADC_W-1:0]  raw_clean;
  logic [15:0]       filt_sum;
  logic [ADC_W-1:0]  lvl_d;
  logic [RW-1:0]     tbl_row;
  logic              tbl_wr;
  logic [ADC_W-1:0]  tbl_rdata;
  logic [TEMP_W-1:0] tp0;
  logic [TEMP_W-1:0] tp1;
  logic              key_hit;
  logic [TEMP_W-1:0] interp;
  logic              out_free;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign sens_ok    = (32'(sensor_i) < SENSOR_COUNT);
  assign out_free   = !out_valid_q || !out_stall_i;

  // bed sample cleaning and filter update: (level*15 + sample) / 16
  assign is_bed    = (sens_q == SW'(BED_SENSOR));
  assign bed_low   = is_bed && (sample_q < BED_MIN_GOOD);
  assign raw_clean = bed_low ? last_good_q : sample_q;
  assign filt_sum  = {filt_q[sens_q], 4'b0000} - 16'(filt_q[sens_q]) + 16'(raw_clean);
  assign lvl_d     = filt_sum[15:4];

  // table address for the beat read next cycle
  always_comb begin
    case (state_q)
      S_FILT:  tbl_row = '0;
      S_CHK0:  tbl_row = LAST_ROW;
      S_CHKL:  tbl_row = RW'(1);
      S_SCAN:  tbl_row = row_q + 1'b1;
      default: tbl_row = row_q;
    endcase
  end

  assign key_hit = (row_temp(ROW_W'(row_q)) == key_q);
  assign tbl_wr  = (state_q == S_KEY) && key_hit && (mode_q == MODE_WRITE);

  // temperatures bracketing the hit row
  assign tp0 = row_temp(ROW_W'(row_q - 1'b1));
  assign tp1 = row_temp(ROW_W'(row_q));

  // step lies between the two temperatures, so no clamp is reached
  assign interp = dneg_q ? (t0_q - div_rsp.quotient) : (t0_q + div_rsp.quotient);

  assign div_req.start    = (state_q == S_MUL);
  assign div_req.dividend = PROD_W'(dlt_q) * PROD_W'(dmag_q);
  assign div_req.divisor  = den_q;

  tfl_bp_table #(
    .TABLE_ROWS  (TABLE_ROWS),
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .row_i    (tbl_row),
    .sens_i   (sens_q),
    .wr_en_i  (tbl_wr),
    .wr_data_i(entry_q),
    .rd_data_o(tbl_rdata)
  );

  tfl_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer, sensor state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mode_q        <= '0;
      sens_q        <= '0;
      sample_q      <= '0;
      key_q         <= '0;
      entry_q       <= '0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        filt_q[s] <= ADC_MAX;
      end
      last_good_q   <= ADC_MAX;
      lvl_q         <= '0;
      row_q         <= '0;
      a0_q          <= '0;
      a1_q          <= '0;
      t0_q          <= '0;
      dlt_q         <= '0;
      den_q         <= '0;
      dmag_q        <= '0;
      dneg_q        <= 1'b0;
      res_cel_q     <= '0;
      res_found_q   <= 1'b0;
      res_entry_q   <= '0;
      out_valid_q   <= 1'b0;
      celsius_q     <= '0;
      found_q       <= 1'b0;
      entry_value_q <= '0;
    end else begin
      // a taken beat empties the output register unless a new result moves in
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            mode_q      <= mode_i;
            sens_q      <= SW'(sensor_i);
            sample_q    <= sample_i;
            key_q       <= temp_key_i;
            entry_q     <= adc_entry_i;
            row_q       <= '0;
            res_cel_q   <= '0;
            res_found_q <= 1'b0;
            res_entry_q <= '0;
            if (!sens_ok) begin
              state_q <= S_DONE;
            end else if (mode_i == MODE_CONVERT) begin
              state_q <= S_FILT;
            end else if (mode_i == MODE_WRITE || mode_i == MODE_READ) begin
              state_q <= S_KEY;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_FILT: begin
          if (is_bed && !bed_low) begin
            last_good_q <= sample_q;
          end
          filt_q[sens_q] <= lvl_d;
          lvl_q          <= lvl_d;
          state_q        <= S_CHK0;
        end
        S_CHK0: begin
          a0_q <= tbl_rdata;
          if (lvl_q < tbl_rdata) begin
            res_cel_q <= row_temp('0);
            state_q   <= S_DONE;
          end else begin
            state_q <= S_CHKL;
          end
        end
        S_CHKL: begin
          if (lvl_q >= tbl_rdata) begin
            res_cel_q <= row_temp(ROW_W'(LAST_ROW));
            state_q   <= S_DONE;
          end else begin
            row_q   <= RW'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (lvl_q < tbl_rdata) begin
            a1_q    <= tbl_rdata;
            state_q <= S_PREP;
          end else begin
            a0_q  <= tbl_rdata;
            row_q <= row_q + 1'b1;
          end
        end
        S_PREP: begin
          t0_q   <= tp0;
          dlt_q  <= lvl_q - a0_q;
          den_q  <= a1_q - a0_q;
          dneg_q <= (tp1 < tp0);
          dmag_q <= (tp1 < tp0) ? (tp0 - tp1) : (tp1 - tp0);
          if (a1_q <= a0_q) begin
            res_cel_q <= tp0;
            state_q   <= S_DONE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            res_cel_q <= interp;
            state_q   <= S_DONE;
          end
        end
        S_KEY: begin
          if (key_hit) begin
            res_found_q <= 1'b1;
            state_q     <= (mode_q == MODE_READ) ? S_RDE : S_DONE;
          end else if (row_q == LAST_ROW) begin
            state_q <= S_DONE;
          end else begin
            row_q <= row_q + 1'b1;
          end
        end
        S_RDE: begin
          res_entry_q <= tbl_rdata;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            celsius_q     <= res_cel_q;
            found_q       <= res_found_q;
            entry_value_q <= res_entry_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign celsius_o     = celsius_q;
  assign found_o       = found_q;
  assign entry_value_o = entry_value_q;

endmodule
